// ----- hw/rtl/sctrx_pkg.sv -----
package sctrx_pkg;

	// frame length: start, 8 data, parity, guard bit(s)
	localparam int FRAME_BITS_DEF = 11;

	localparam logic [7:0] BIT_TOP_RST      = 8'd186;
	localparam logic [7:0] SAMPLE_POINT_RST = 8'd93;

	// configuration register indexes
	localparam logic CFG_BIT_TOP      = 1'b0;
	localparam logic CFG_SAMPLE_POINT = 1'b1;

	// mode codes; the unused code behaves as idle
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_TX   = 2'd1;
	localparam logic [1:0] MODE_RX   = 2'd2;

	// receive sample numbers
	localparam logic [3:0] RX_FIRST_DATA  = 4'd1;
	localparam logic [3:0] RX_LAST_DATA   = 4'd8;
	localparam logic [3:0] RX_LAST_SAMPLE = 4'd10;

endpackage

// ----- hw/rtl/smart_card_char_transceiver_top.sv -----
// Half-duplex single-wire character transceiver for smart-card (ISO 7816-3
// style) characters. Every input transaction is one tick of the bit timer and
// yields exactly one output transaction that shows the state after that tick.
// One bit time is bit_top + 1 ticks. cmd = 1 starts sending tx_byte at once:
// start bit, 8 data bits LSB first, even parity, then guard bit(s) up to
// FRAME_BITS bits; the line is then released (line_enable = 0). A new cmd
// restarts a running send and drops any reception in progress. While idle, a
// falling edge on line_in starts reception; the line is sampled at tick
// sample_point of each bit time (clamped to bit_top), and the byte appears
// with rx_valid = 1 at the guard-bit sample. Parity is not checked.
// Throughput: one tick per clock unless stalled. The tick's work sits between
// the state registers and the output register, so a result shows in the cycle
// after its input transaction; in_stall rises only while the output register
// holds a result that the downstream side is stalling. Configuration (bit_top
// at index 0, sample_point at index 1) is written through cfg_we / cfg_index /
// cfg_data; the user must do so only while no tick is in flight (unenforced).
module smart_card_char_transceiver_top
	import sctrx_pkg::*;
#(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,

	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd,
	input  logic [7:0] tx_byte,
	input  logic       line_in,

	output logic       out_valid,
	input  logic       out_stall,
	output logic       line_drive,
	output logic       line_enable,
	output logic       rx_valid,
	output logic [7:0] rx_byte,
	output logic       tx_busy,
	output logic       rx_busy
);

	localparam int IDX_W = $clog2(FRAME_BITS);

	// configuration
	logic [7:0] bit_top_q;
	logic [7:0] sample_point_q;

	// transceiver state
	logic [7:0]            tick_q,     tick_n;
	logic [FRAME_BITS-1:0] tx_frame_q, tx_frame_n;
	logic [IDX_W-1:0]      tx_index_q, tx_index_n;
	logic [3:0]            rx_index_q, rx_index_n;
	logic [7:0]            rx_shift_q, rx_shift_n;
	logic [1:0]            mode_q,     mode_n;
	logic                  prev_line_q;

	// tick logic helpers
	logic             accept;
	logic             wrap;
	logic [7:0]       tick_inc;
	logic [7:0]       eff_sample;
	logic [IDX_W:0]   tx_index_inc;
	logic             do_sample;
	logic [3:0]       sample_idx;
	logic [2:0]       shift_pos;
	logic             valid_n;
	logic [7:0]       byte_n;
	logic             parity;

	// output stage: full unless drained this cycle
	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_top_q      <= BIT_TOP_RST;
			sample_point_q <= SAMPLE_POINT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BIT_TOP:      bit_top_q      <= cfg_data;
				CFG_SAMPLE_POINT: sample_point_q <= cfg_data;
				default:          bit_top_q      <= bit_top_q;
			endcase
		end
	end

	assign wrap         = tick_q >= bit_top_q;
	assign tick_inc     = wrap ? 8'd0 : tick_q + 8'd1;
	assign eff_sample   = (sample_point_q > bit_top_q) ? bit_top_q : sample_point_q;
	assign tx_index_inc = {1'b0, tx_index_q} + {{IDX_W{1'b0}}, 1'b1};
	assign parity       = ^tx_byte;
	assign shift_pos    = 3'(sample_idx - RX_FIRST_DATA);

	// next state for one tick
	always_comb begin
		tick_n     = tick_q;
		tx_frame_n = tx_frame_q;
		tx_index_n = tx_index_q;
		rx_index_n = rx_index_q;
		rx_shift_n = rx_shift_q;
		mode_n     = mode_q;
		do_sample  = 1'b0;
		sample_idx = rx_index_q;

		if (cmd) begin
			tx_frame_n = {{(FRAME_BITS-10){1'b1}}, parity, tx_byte, 1'b0};
			tx_index_n = '0;
			tick_n     = 8'd0;
			mode_n     = MODE_TX;
			rx_index_n = 4'd0;
			rx_shift_n = 8'd0;
		end else begin
			case (mode_q)
				MODE_TX: begin
					tick_n = tick_inc;
					if (wrap) begin
						if (tx_index_inc >= (IDX_W+1)'(FRAME_BITS)) begin
							tx_index_n = '0;
							mode_n     = MODE_IDLE;
						end else begin
							tx_index_n = tx_index_inc[IDX_W-1:0];
						end
					end
				end
				MODE_RX: begin
					tick_n    = tick_inc;
					do_sample = (tick_inc == eff_sample);
				end
				default: begin
					mode_n = MODE_IDLE;
					if (prev_line_q && !line_in) begin
						// falling edge: start bit; sample now if the point is zero
						mode_n     = MODE_RX;
						tick_n     = 8'd0;
						rx_index_n = 4'd0;
						rx_shift_n = 8'd0;
						sample_idx = 4'd0;
						do_sample  = (eff_sample == 8'd0);
					end
				end
			endcase
		end

		valid_n = 1'b0;
		byte_n  = 8'd0;
		if (do_sample) begin
			if (sample_idx >= RX_FIRST_DATA && sample_idx <= RX_LAST_DATA) begin
				rx_shift_n = rx_shift_n | (8'(line_in) << shift_pos);
			end
			if (sample_idx >= RX_LAST_SAMPLE) begin
				valid_n    = 1'b1;
				byte_n     = rx_shift_n;
				mode_n     = MODE_IDLE;
				rx_index_n = 4'd0;
			end else begin
				rx_index_n = sample_idx + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= 8'd0;
			tx_frame_q  <= '1;
			tx_index_q  <= '0;
			rx_index_q  <= 4'd0;
			rx_shift_q  <= 8'd0;
			mode_q      <= MODE_IDLE;
			prev_line_q <= 1'b1;
		end else if (accept) begin
			tick_q      <= tick_n;
			tx_frame_q  <= tx_frame_n;
			tx_index_q  <= tx_index_n;
			rx_index_q  <= rx_index_n;
			rx_shift_q  <= rx_shift_n;
			mode_q      <= mode_n;
			prev_line_q <= line_in;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_enable <= (mode_n == MODE_TX);
			line_drive  <= (mode_n == MODE_TX) ? tx_frame_n[tx_index_n] : 1'b1;
			rx_valid    <= valid_n;
			rx_byte     <= byte_n;
			tx_busy     <= (mode_n == MODE_TX);
			rx_busy     <= (mode_n == MODE_RX);
		end
	end

	// a send command drives the start bit on the very next result
	a_start_bit: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd |=> out_valid && line_enable && !line_drive && tx_busy)
		else $error("start bit not driven after send command");

	// a completed character ends reception and never coexists with a send
	a_rx_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_valid |-> !rx_busy && !tx_busy && !line_enable)
		else $error("rx_valid while still busy");

	// released line reads high
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_enable |-> line_drive)
		else $error("line_drive low while released");

	// transmit bit index stays within the frame
	a_tx_index: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_TX |-> tx_index_q < IDX_W'(FRAME_BITS - 1) ||
			tx_index_q == IDX_W'(FRAME_BITS - 1))
		else $error("tx_index beyond frame");

	// receive counter never passes the guard sample
	a_rx_index: assert property (@(posedge clk) disable iff (!arst_n)
		rx_index_q <= RX_LAST_SAMPLE)
		else $error("rx_index beyond guard sample");

endmodule
